/* hdl/b64d_pkg.sv */
// Shared types, codes and the character classifier for the base64 stream decoder.
package b64d_pkg;

	// Classifier results: 0..63 are alphabet values, the rest are markers
	localparam logic [8:0] SYM_IGNORE = 9'h100;
	localparam logic [8:0] SYM_BAD    = 9'h101;
	localparam logic [8:0] SYM_PAD    = 9'h102;
	localparam logic [7:0] BYTE_MASK  = 8'hff;

	// End-of-message status codes
	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_HIGH_CODE  = 3'd1;
	localparam logic [2:0] ST_BAD_CHAR   = 3'd2;
	localparam logic [2:0] ST_AFTER_END  = 3'd3;
	localparam logic [2:0] ST_EARLY_PAD  = 3'd4;
	localparam logic [2:0] ST_AFTER_PAD  = 3'd5;
	localparam logic [2:0] ST_INCOMPLETE = 3'd6;

	// Result kinds
	localparam logic KIND_DATA   = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	typedef struct packed {
		logic [7:0] char_code;
		logic       end_of_text;
	} b64d_char_t;

	typedef struct packed {
		logic       result_kind;
		logic [7:0] data_byte;
		logic [2:0] status_code;
		logic       run_last;
	} b64d_result_t;

	// One queue entry: everything one input word leaves for the output side
	typedef struct packed {
		logic [1:0]  n_data;
		logic [23:0] group;
		logic        has_status;
		logic [2:0]  status;
	} b64d_job_t;

	// Queue status seen by both sides
	typedef struct packed {
		logic full;
		logic empty;
	} b64d_q_stat_t;

	function automatic logic [8:0] b64d_classify(input logic [7:0] c);
		logic [8:0] sym;
		sym = SYM_BAD;
		case (c) inside
			[8'd65:8'd90]:  sym = {1'b0, c - 8'd65};
			[8'd97:8'd122]: sym = {1'b0, c - 8'd71};
			[8'd48:8'd57]:  sym = {1'b0, c + 8'd4};
			8'd43:          sym = 9'd62;
			8'd47:          sym = 9'd63;
			8'd61:          sym = SYM_PAD;
			8'd10, 8'd13:   sym = SYM_IGNORE;
			default:        sym = SYM_BAD;
		endcase
		return sym;
	endfunction

endpackage

/* hdl/b64d_if.sv */
// Valid/ready stream interfaces for the character and result channels.
interface b64d_char_if import b64d_pkg::*; ();
	logic       valid;
	logic       ready;
	b64d_char_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface b64d_result_if import b64d_pkg::*; ();
	logic         valid;
	logic         ready;
	b64d_result_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

/* hdl/b64d_front.sv */
// Front end: accepts characters, tracks group and error state, queues output jobs.
module b64d_front import b64d_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  b64d_char_t   in_word,
	input  b64d_q_stat_t q_stat,
	output logic         push,
	output b64d_job_t    job
);

	logic [23:0] grp_q, grp_n, grp_shift;
	logic [1:0]  sym_q, sym_n;
	logic [1:0]  pad_q, pad_n, pad_inc;
	logic        done_q, done_n;
	logic [2:0]  err_q, err_n;
	logic [8:0]  cls;
	logic        is_pad;
	logic        accept;
	logic [1:0]  n_data;

	assign in_ready = !q_stat.full;
	assign accept   = in_valid && in_ready;

	assign cls       = b64d_classify(in_word.char_code);
	assign is_pad    = (cls == SYM_PAD);
	assign grp_shift = {grp_q[17:0], (is_pad ? 6'd0 : cls[5:0])};
	assign pad_inc   = pad_q + {1'b0, is_pad};

	// Next decode state for the word on the input
	always_comb begin
		grp_n  = grp_q;
		sym_n  = sym_q;
		pad_n  = pad_q;
		done_n = done_q;
		err_n  = err_q;
		n_data = 2'd0;
		if (err_q == ST_OK) begin
			if (in_word.char_code[7]) begin
				err_n = ST_HIGH_CODE;
			end else if (cls == SYM_IGNORE) begin
				err_n = ST_OK;
			end else if (done_q) begin
				err_n = ST_AFTER_END;
			end else if (cls == SYM_BAD) begin
				err_n = ST_BAD_CHAR;
			end else if (is_pad && pad_q == 2'd0 && sym_q < 2'd2) begin
				err_n = ST_EARLY_PAD;
			end else if (!is_pad && pad_q != 2'd0) begin
				err_n = ST_AFTER_PAD;
			end else if (sym_q == 2'd3) begin
				// group complete: padding trims the byte count and ends the message
				case (pad_inc)
					2'd0:    n_data = 2'd3;
					2'd1:    n_data = 2'd2;
					default: n_data = 2'd1;
				endcase
				done_n = (pad_inc != 2'd0);
				sym_n  = 2'd0;
				pad_n  = 2'd0;
				grp_n  = 24'd0;
			end else begin
				sym_n = sym_q + 2'd1;
				pad_n = pad_inc;
				grp_n = grp_shift;
			end
		end
	end

	// Job for the back end: data bytes and, at end of text, the status
	always_comb begin
		job.n_data     = n_data;
		job.group      = grp_shift;
		job.has_status = in_word.end_of_text;
		job.status     = (err_n == ST_OK && sym_n != 2'd0) ? ST_INCOMPLETE : err_n;
	end

	assign push = accept && (n_data != 2'd0 || in_word.end_of_text);

	// Decode state; end of text clears everything
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_q  <= 24'd0;
			sym_q  <= 2'd0;
			pad_q  <= 2'd0;
			done_q <= 1'b0;
			err_q  <= ST_OK;
		end else if (accept) begin
			if (in_word.end_of_text) begin
				grp_q  <= 24'd0;
				sym_q  <= 2'd0;
				pad_q  <= 2'd0;
				done_q <= 1'b0;
				err_q  <= ST_OK;
			end else begin
				grp_q  <= grp_n;
				sym_q  <= sym_n;
				pad_q  <= pad_n;
				done_q <= done_n;
				err_q  <= err_n;
			end
		end
	end

	a_eot_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_word.end_of_text) |=> (sym_q == 2'd0 && pad_q == 2'd0
			&& !done_q && err_q == ST_OK))
		else $error("state not cleared after end of text");

	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(err_q != ST_OK && !(accept && in_word.end_of_text)) |=> (err_q == $past(err_q)))
		else $error("error code changed before end of text");

	a_pad_range: assert property (@(posedge clk) disable iff (!arst_n)
		(pad_q != 2'd3) && !(pad_q != 2'd0 && sym_q < 2'd3 && sym_q < 2'd2 && pad_q > sym_q))
		else $error("pad count out of range");

endmodule

/* hdl/b64d_queue.sv */
// Small job queue between the front and back ends.
module b64d_queue import b64d_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  b64d_job_t    push_job,
	input  logic         pop,
	output b64d_job_t    head_job,
	output b64d_q_stat_t q_stat
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
	localparam logic [PW-1:0] PTR_ONE  = PW'(1);
	localparam logic [CW-1:0] CNT_ONE  = CW'(1);

	b64d_job_t       mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign q_stat.full  = (count_q == FULL_CNT);
	assign q_stat.empty = (count_q == '0);
	assign head_job     = mem_q[rd_ptr_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_ONE;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_ONE;
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_ONE;
			end else if (pop && !push) begin
				count_q <= count_q - CNT_ONE;
			end
		end
	end

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q <= FULL_CNT) && !(push && q_stat.full && !pop) && !(pop && q_stat.empty))
		else $error("queue overrun or underrun");

endmodule

/* hdl/b64d_back.sv */
// Back end: expands queued jobs into result words through an output register.
module b64d_back import b64d_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  b64d_q_stat_t q_stat,
	input  b64d_job_t    head_job,
	output logic         pop,
	output logic         out_valid,
	input  logic         out_ready,
	output b64d_result_t out_word
);

	logic [1:0]   idx_q;
	logic         out_valid_q;
	b64d_result_t out_q;
	logic [2:0]   total;
	logic         last;
	logic         load;
	logic         is_data;
	logic [7:0]   sel_byte;
	b64d_result_t res;

	assign total   = {1'b0, head_job.n_data} + {2'b0, head_job.has_status};
	assign last    = ({1'b0, idx_q} + 3'd1) == total;
	assign is_data = idx_q < head_job.n_data;
	assign load    = !q_stat.empty && (!out_valid_q || out_ready);
	assign pop     = load && last;

	// Byte of the group for this result, most significant first
	always_comb begin
		case (idx_q)
			2'd0:    sel_byte = head_job.group[23:16];
			2'd1:    sel_byte = head_job.group[15:8];
			default: sel_byte = head_job.group[7:0];
		endcase
	end

	always_comb begin
		res.result_kind = is_data ? KIND_DATA : KIND_STATUS;
		res.data_byte   = is_data ? (sel_byte & BYTE_MASK) : 8'd0;
		res.status_code = is_data ? ST_OK : head_job.status;
		res.run_last    = last;
	end

	// Output register and position within the current job
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else if (load) begin
			idx_q       <= last ? 2'd0 : idx_q + 2'd1;
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_q;

	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.result_kind == KIND_STATUS) |->
			(out_q.run_last && out_q.data_byte == 8'd0))
		else $error("status word not last or carries data");

	a_idx_reset: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (idx_q == 2'd0))
		else $error("job index not rewound after pop");

endmodule

/* hdl/base64_stream_decoder.sv */
// Top level of the streaming base64 decoder.
//
// chars:   one text character per word (char_code, end_of_text).
// results: data bytes (result_kind 0) and one status word per message
//          (result_kind 1, status_code); run_last marks the final result of
//          the character that caused it.
// A character is taken every cycle while the job queue has room. Its results
// pass through the job queue and then the output register, one result per
// cycle while results.ready is high. A completed group gives up to three
// results, an end-of-text character up to four, so the output register and
// the one-word-per-cycle result port set the sustained rate: one character
// per cycle while results are drained.
// Line feed and carriage return and characters that finish no group give no
// result unless they end the text.
// When results.ready is low the output register holds its word; the front end
// keeps accepting until QUEUE_DEPTH jobs wait, then drops chars.ready.
// Reset clears the decode state, the queue and the output valid at once.
module base64_stream_decoder import b64d_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	b64d_char_if.sink     chars,
	b64d_result_if.source results
);

	b64d_q_stat_t q_stat;
	b64d_job_t    push_job;
	b64d_job_t    head_job;
	logic         push;
	logic         pop;

	b64d_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (chars.valid),
		.in_ready (chars.ready),
		.in_word  (chars.payload),
		.q_stat   (q_stat),
		.push     (push),
		.job      (push_job)
	);

	b64d_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head_job (head_job),
		.q_stat   (q_stat)
	);

	b64d_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_stat    (q_stat),
		.head_job  (head_job),
		.pop       (pop),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.out_word  (results.payload)
	);

endmodule
